// ===== rtl/core/ffea_pkg.sv =====
// Package for the first-fit extent allocator.
// Holds status codes, operation codes and the cell command struct.
// No dependencies.
package ffea_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_OVERLAP = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam int SIZE_BITS = 17;

  // Per-cell command: what every cell does this cycle.
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_SHL    = 2'd1; // entry i takes entry i+1 (i >= pos)
  localparam logic [1:0] CMD_SHR    = 2'd2; // entry i takes entry i-1 (i > pos)
  localparam logic [1:0] CMD_ROT    = 2'd3; // circular step of the walk

  typedef struct packed {
    logic [1:0] cmd;
    logic       wr;    // overwrite the cell at pos (after shift)
  } cell_ctl_t;

endpackage

// ===== rtl/core/ffea_cell.sv =====
// One table cell: holds an extent start and length, takes its neighbor's
// entry on shift commands. Depends on ffea_pkg.
module ffea_cell #(
  parameter int ADDR_BITS = 16,
  parameter int LEN_BITS  = 18
) (
  input  logic                 clk,
  input  ffea_pkg::cell_ctl_t  ctl,
  input  logic                 at_or_above, // index >= pos
  input  logic                 above,       // index > pos
  input  logic [ADDR_BITS-1:0] left_start,
  input  logic [LEN_BITS-1:0]  left_len,
  input  logic [ADDR_BITS-1:0] right_start,
  input  logic [LEN_BITS-1:0]  right_len,
  input  logic                 wr_here,
  input  logic [ADDR_BITS-1:0] wr_start,
  input  logic [LEN_BITS-1:0]  wr_len,
  output logic [ADDR_BITS-1:0] start,
  output logic [LEN_BITS-1:0]  len
);
  import ffea_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.wr && wr_here) begin
      start <= wr_start;
      len   <= wr_len;
    end else begin
      case (ctl.cmd)
        CMD_SHL: if (at_or_above) begin
          start <= right_start;
          len   <= right_len;
        end
        CMD_SHR: if (above) begin
          start <= left_start;
          len   <= left_len;
        end
        CMD_ROT: begin
          start <= right_start;
          len   <= right_len;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/core/first_fit_extent_allocator_unit.sv =====
// First-fit extent allocator: top level, sequencer plus row of cells.
// Depends on ffea_pkg and ffea_cell.
//
// Usage: pulse start with operation, address and request_size while busy is
// low. The block walks the table by rotating the row of cells one entry per
// cycle, so cell 0 always shows the entry under inspection; the walk always
// makes MAX_EXTENTS steps to restore order. The decision is then applied by
// a shift, a write or both. A result appears on area_address/status with
// done high for one cycle.
// Busy is high from the accepting edge through the walk, apply and done
// states, so the next item is taken only once the last one is through; the
// loop that sets this is the rotation of the row.
// Configuration: cfg_valid/cfg_ready writes min_fragment_bytes; cfg_ready
// is high whenever the block is idle.
// Reset: table empty, min_fragment_bytes = 8, block idle. Entry contents are
// undefined until written. The receiver cannot stall; done is one cycle.
module first_fit_extent_allocator_unit #(
  parameter int MAX_EXTENTS = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [ADDR_BITS-1:0]          address,
  input  logic [ffea_pkg::SIZE_BITS-1:0] request_size,
  output logic                          done,
  output logic [ADDR_BITS-1:0]          area_address,
  output logic [1:0]                    status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [6:0]                    cfg_data
);
  import ffea_pkg::*;

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int SW = SIZE_BITS;
  // lengths hold a rounded request or a whole address space
  localparam int LW = ((ADDR_BITS > SW) ? ADDR_BITS : SW) + 1;
  localparam int XW = LW + 1; // sums of address, size and fragment limit
  localparam logic [XW-1:0] SPACE = XW'(1) << ADDR_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state;
  logic [CW-1:0]        count;
  logic [CW-1:0]        step;
  logic [6:0]           min_frag;
  logic                 op;
  logic [ADDR_BITS-1:0] p;
  logic [LW-1:0]        size;
  // walk findings
  logic                 found;
  logic [IW-1:0]        fpos;
  logic                 exact;
  logic [CW-1:0]        ipos;     // free: insert position
  logic [ADDR_BITS-1:0] l_start;
  logic [LW-1:0]        l_len;
  logic [ADDR_BITS-1:0] c_start;
  logic [LW-1:0]        c_len;

  logic [ADDR_BITS-1:0] cs [MAX_EXTENTS];
  logic [LW-1:0]        cl [MAX_EXTENTS];
  cell_ctl_t            ctl;
  logic [IW-1:0]        pos;
  logic [ADDR_BITS-1:0] wr_start;
  logic [LW-1:0]        wr_len;

  // Input rounding and clipping.
  logic [SW:0]   rs;
  logic [LW-1:0] rsize;
  logic [XW-1:0] room;
  logic [LW-1:0] fsize;
  assign rs    = {1'b0, request_size} + (SW+1)'(3);
  assign rsize = LW'({rs[SW:2], 2'b00});
  assign room  = SPACE - XW'(address);
  assign fsize = (XW'(rsize) > room) ? LW'(room) : rsize;

  // Walk-step decisions on cell 0.
  logic          in_tab;
  logic [XW-1:0] need;
  assign in_tab = step < count;
  assign need   = XW'(size) + XW'(min_frag);

  // Free-path decisions after the walk.
  logic          has_l, has_c, ov, m_l, m_c;
  logic [XW-1:0] l_end, p_end;
  assign has_l = ipos != '0;
  assign has_c = ipos < count;
  assign l_end = XW'(l_start) + XW'(l_len);
  assign p_end = XW'(p) + XW'(size);
  assign ov  = (has_l && l_end > XW'(p)) || (has_c && p_end > XW'(c_start));
  assign m_l = has_l && l_end == XW'(p);
  assign m_c = has_c && p_end == XW'(c_start);

  assign busy      = state != S_IDLE;
  assign cfg_ready = state == S_IDLE;

  // Row of cells.
  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    localparam int L = (i == 0) ? MAX_EXTENTS - 1 : i - 1;
    localparam int R = (i == MAX_EXTENTS - 1) ? 0 : i + 1;
    ffea_cell #(.ADDR_BITS(ADDR_BITS), .LEN_BITS(LW)) u_cell (
      .clk(clk), .ctl(ctl),
      .at_or_above(IW'(i) >= pos), .above(IW'(i) > pos),
      .left_start(cs[L]), .left_len(cl[L]),
      .right_start(cs[R]), .right_len(cl[R]),
      .wr_here(IW'(i) == pos), .wr_start(wr_start), .wr_len(wr_len),
      .start(cs[i]), .len(cl[i])
    );
  end

  // Cell command for the walk and apply states, and the result.
  logic [1:0] res_st;
  logic [ADDR_BITS-1:0] res_addr;
  always_comb begin
    ctl      = '{cmd: CMD_HOLD, wr: 1'b0};
    pos      = fpos;
    wr_start = p;
    wr_len   = size;
    res_st   = ST_OK;
    res_addr = '0;
    if (state == S_WALK) begin
      ctl.cmd = CMD_ROT;
    end else if (state == S_APPLY) begin
      if (op == OP_ALLOC) begin
        if (!found || size == '0) begin
          res_st = ST_NOFIT;
        end else if (exact) begin
          ctl.cmd  = CMD_SHL;
          res_addr = c_start;
        end else begin
          ctl.wr   = 1'b1;
          wr_start = c_start;
          wr_len   = c_len - size;
          res_addr = c_start + ADDR_BITS'(c_len - size);
        end
      end else if (size != '0) begin
        if (ov) begin
          res_st = ST_OVERLAP;
        end else if (m_l && m_c) begin
          // predecessor grows, successor removed: shift left at ipos, write ipos-1
          ctl.cmd  = CMD_SHL;
          ctl.wr   = 1'b1;
          pos      = IW'(ipos - CW'(1));
          wr_start = l_start;
          wr_len   = l_len + size + c_len;
        end else if (m_l) begin
          ctl.wr   = 1'b1;
          pos      = IW'(ipos - CW'(1));
          wr_start = l_start;
          wr_len   = l_len + size;
        end else if (m_c) begin
          ctl.wr   = 1'b1;
          pos      = IW'(ipos);
          wr_len   = c_len + size;
        end else if (count >= CW'(MAX_EXTENTS)) begin
          res_st = ST_FULL;
        end else begin
          ctl.cmd = CMD_SHR;
          ctl.wr  = 1'b1;
          pos     = IW'(ipos);
        end
      end
    end
  end

  // On a double merge the shift starts at ipos-1 too; the write takes that
  // cell, and the cells above take their right neighbor, dropping entry ipos.

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      min_frag <= 7'd8;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) min_frag <= cfg_data;
      unique case (state)
        S_IDLE: if (start) begin
          op    <= operation;
          p     <= address;
          size  <= (operation == OP_FREE) ? fsize : rsize;
          step  <= '0;
          found <= 1'b0;
          exact <= 1'b0;
          ipos  <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          if (in_tab) begin
            if (op == OP_ALLOC) begin
              if (!found && (XW'(cl[0]) == XW'(size) || need <= XW'(cl[0]))) begin
                found   <= 1'b1;
                exact   <= XW'(cl[0]) == XW'(size);
                fpos    <= IW'(step);
                c_start <= cs[0];
                c_len   <= cl[0];
              end
            end else if (cs[0] <= p && ipos == step) begin
              ipos    <= step + CW'(1);
              l_start <= cs[0];
              l_len   <= cl[0];
            end else if (ipos == step) begin
              c_start <= cs[0];
              c_len   <= cl[0];
            end
          end
          step <= step + CW'(1);
          if (step == CW'(MAX_EXTENTS - 1)) state <= S_APPLY;
        end
        S_APPLY: begin
          area_address <= res_addr;
          status       <= res_st;
          done         <= 1'b1;
          if (res_st == ST_OK && op == OP_ALLOC && exact) count <= count - CW'(1);
          if (res_st == ST_OK && op == OP_FREE && size != '0) begin
            if (m_l && m_c) count <= count - CW'(1);
            else if (!m_l && !m_c) count <= count + CW'(1);
          end
          state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_EXTENTS)) else $error("extent count overflow");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item not taken");
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> area_address == '0) else $error("addr on error");
endmodule
